// ----- design/rlre_pkg.sv -----
// shared types and codes of the ring level routing engine
package rlre_pkg;

	localparam logic [7:0] NONE8 = 8'hFF;

	localparam logic [2:0] REQ_START = 3'd0;
	localparam logic [2:0] REQ_TICK  = 3'd1;
	localparam logic [2:0] REQ_SETUP = 3'd2;
	localparam logic [2:0] REQ_DATA  = 3'd3;
	localparam logic [2:0] REQ_APP   = 3'd4;

	localparam logic [2:0] DST_BCAST  = 3'd0;
	localparam logic [2:0] DST_SELF   = 3'd1;
	localparam logic [2:0] DST_SINK   = 3'd2;
	localparam logic [2:0] DST_PARENT = 3'd3;

	localparam logic [1:0] CFG_IS_SINK  = 2'd0;
	localparam logic [1:0] CFG_SELF_ID  = 2'd1;
	localparam logic [1:0] CFG_WIN_TICK = 2'd2;

	typedef enum logic [3:0] {
		ACT_DROP      = 4'd0,
		ACT_DELIVER   = 4'd1,
		ACT_REBCAST   = 4'd2,
		ACT_SEND      = 4'd3,
		ACT_HOLD      = 4'd4,
		ACT_RELEASE   = 4'd5,
		ACT_SETUP     = 4'd6,
		ACT_CONNECTED = 4'd7,
		ACT_LEVEL_UPD = 4'd8,
		ACT_NOT_CONN  = 4'd9
	} act_t;

	typedef struct packed {
		act_t        action;
		logic [7:0]  level;
		logic [7:0]  sink;
		logic [15:0] seq;
		logic        last;
	} result_t;

	typedef struct packed {
		logic              fire;
		logic [1:0]        n;
		result_t [2:0]     res;
	} emit_t;

	typedef struct packed {
		logic        seen;
		logic [15:0] seq;
	} tbl_entry_t;

	typedef struct packed {
		logic        en;
		logic [7:0]  src;
		logic [15:0] seq;
	} tbl_wr_t;

endpackage

// ----- design/rlre_ifs.sv -----
// channel interfaces: request, result and configuration write
interface rlre_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [2:0]  dst_kind;
	logic [7:0]  src_addr;
	logic [7:0]  sender_level;
	logic [7:0]  pkt_sink;
	logic [15:0] pkt_seq;

	modport source (output valid, req_type, dst_kind, src_addr, sender_level, pkt_sink,
		pkt_seq, input ready);
	modport sink (input valid, req_type, dst_kind, src_addr, sender_level, pkt_sink,
		pkt_seq, output ready);
endinterface

interface rlre_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic [7:0]  level_out;
	logic [7:0]  sink_out;
	logic [15:0] seq_out;
	logic        last;

	modport source (output valid, action, level_out, sink_out, seq_out, last, input ready);
	modport sink (input valid, action, level_out, sink_out, seq_out, last, output ready);
endinterface

interface rlre_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/rlre_src_table.sv -----
// per-source sequence filter memory with clearing sweep and write forwarding
module rlre_src_table #(
	parameter int MAX_NODES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [7:0]          rd_src,
	input  rlre_pkg::tbl_wr_t   wr,
	input  logic                clr_start,
	output rlre_pkg::tbl_entry_t rd_entry,
	output logic                clearing
);

	localparam int AW = $clog2(MAX_NODES);

	logic [AW-1:0]        idx_of [256];
	rlre_pkg::tbl_entry_t mem [MAX_NODES];
	rlre_pkg::tbl_entry_t rdata_q;
	rlre_pkg::tbl_entry_t fwd_data_q;
	rlre_pkg::tbl_entry_t wr_data;
	logic                 fwd_hit_q;
	logic                 clearing_q;
	logic [AW-1:0]        clr_idx_q;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic                 wr_en;

	// source address folded onto the table depth
	for (genvar g = 0; g < 256; g++) begin : g_idx
		assign idx_of[g] = AW'(g % MAX_NODES);
	end

	assign rd_addr = idx_of[rd_src];
	assign wr_addr = clearing_q ? clr_idx_q : idx_of[wr.src];
	assign wr_en   = clearing_q || wr.en;

	always_comb begin
		wr_data.seen = !clearing_q;
		wr_data.seq  = clearing_q ? 16'd0 : wr.seq;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q    <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// a write landing on the entry being read in the same cycle wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q  <= 1'b0;
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			if (rd_en) begin
				fwd_hit_q <= wr_en && (wr_addr == rd_addr);
			end
			if (clearing_q) begin
				if (clr_idx_q == AW'(MAX_NODES - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_idx_q <= clr_idx_q + 1'b1;
				end
			end else if (clr_start) begin
				clearing_q <= 1'b1;
				clr_idx_q  <= '0;
			end
		end
	end

	assign rd_entry = fwd_hit_q ? fwd_data_q : rdata_q;
	assign clearing = clearing_q;

	a_no_wr_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !clearing_q)
		else $error("filter update during clearing sweep");

endmodule

// ----- design/rlre_ctrl.sv -----
// event stage: config, routing state, filter read-modify-write, result build
module rlre_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	rlre_req_if.sink             req,
	rlre_cfg_if.sink             cfg,
	output logic                 rd_en,
	output logic [7:0]           rd_src,
	output rlre_pkg::tbl_wr_t    wr,
	output logic                 clr_start,
	input  rlre_pkg::tbl_entry_t rd_entry,
	input  logic                 clearing,
	input  logic                 buf_free,
	output rlre_pkg::emit_t      emit
);

	// config
	logic        is_sink_q;
	logic [7:0]  self_id_q;
	logic [15:0] win_q;

	// routing state
	logic [7:0]  own_level_q, own_level_d;
	logic [7:0]  own_sink_q, own_sink_d;
	logic [7:0]  best_level_q, best_level_d;
	logic [7:0]  best_sink_q, best_sink_d;
	logic        joined_q, joined_d;
	logic        armed_q, armed_d;
	logic [15:0] left_q, left_d;
	logic [15:0] next_seq_q, next_seq_d;
	logic        holding_q, holding_d;

	// event stage
	logic        valid_s1;
	logic [2:0]  req_s1;
	logic [2:0]  dst_s1;
	logic [7:0]  src_s1;
	logic [7:0]  slev_s1;
	logic [7:0]  psink_s1;
	logic [15:0] pseq_s1;

	logic                        in_rdy;
	logic                        accept;
	logic                        fire;
	logic                        filt_ok;
	logic                        lvl_ok;
	logic                        tbl_upd;
	logic [7:0]                  lvl_new;
	logic [7:0]                  bl_eff;
	logic [1:0]                  n;
	rlre_pkg::result_t [2:0]     res;

	assign fire   = valid_s1 && buf_free;
	// nothing enters behind a start until the filter sweep is over
	assign in_rdy = !clearing && (!valid_s1 || (fire && req_s1 != rlre_pkg::REQ_START));
	assign accept = req.valid && in_rdy;
	assign req.ready = in_rdy;
	assign cfg.ready = 1'b1;

	assign rd_en  = accept;
	assign rd_src = req.src_addr;

	assign filt_ok = !rd_entry.seen || (pseq_s1 > rd_entry.seq);
	assign lvl_ok  = ({1'b0, slev_s1} == ({1'b0, own_level_q} + 9'd1));

	always_comb begin
		own_level_d  = own_level_q;
		own_sink_d   = own_sink_q;
		best_level_d = best_level_q;
		best_sink_d  = best_sink_q;
		joined_d     = joined_q;
		armed_d      = armed_q;
		left_d       = left_q;
		next_seq_d   = next_seq_q;
		holding_d    = holding_q;
		tbl_upd      = 1'b0;
		lvl_new      = best_level_q + 8'd1;
		bl_eff       = armed_q ? best_level_q : rlre_pkg::NONE8;
		n            = 2'd0;
		res          = '0;
		unique case (req_s1)
			rlre_pkg::REQ_START: begin
				own_level_d  = is_sink_q ? 8'd0 : rlre_pkg::NONE8;
				own_sink_d   = is_sink_q ? self_id_q : rlre_pkg::NONE8;
				best_level_d = is_sink_q ? 8'd0 : rlre_pkg::NONE8;
				best_sink_d  = is_sink_q ? self_id_q : rlre_pkg::NONE8;
				joined_d     = is_sink_q;
				armed_d      = 1'b0;
				left_d       = 16'd0;
				next_seq_d   = 16'd0;
				if (is_sink_q) begin
					res[0] = '{rlre_pkg::ACT_SETUP, 8'd0, self_id_q, 16'd0, 1'b1};
					n      = 2'd1;
				end
			end
			rlre_pkg::REQ_TICK: begin
				if (armed_q) begin
					if (left_q <= 16'd1) begin
						left_d  = 16'd0;
						armed_d = 1'b0;
						if (best_level_q == rlre_pkg::NONE8) begin
							// nothing heard: run the window again
							armed_d = 1'b1;
							left_d  = win_q;
						end else if (own_level_q == rlre_pkg::NONE8) begin
							own_level_d = lvl_new;
							own_sink_d  = best_sink_q;
							if (!joined_q) begin
								joined_d = 1'b1;
								res[0] = '{rlre_pkg::ACT_CONNECTED, lvl_new, best_sink_q,
									16'd0, 1'b0};
								if (holding_q) begin
									holding_d = 1'b0;
									res[1] = '{rlre_pkg::ACT_RELEASE, lvl_new, best_sink_q,
										16'd0, 1'b0};
									res[2] = '{rlre_pkg::ACT_SETUP, lvl_new, best_sink_q,
										16'd0, 1'b1};
									n = 2'd3;
								end else begin
									res[1] = '{rlre_pkg::ACT_SETUP, lvl_new, best_sink_q,
										16'd0, 1'b1};
									n = 2'd2;
								end
							end else begin
								res[0] = '{rlre_pkg::ACT_LEVEL_UPD, lvl_new, best_sink_q,
									16'd0, 1'b0};
								res[1] = '{rlre_pkg::ACT_SETUP, lvl_new, best_sink_q,
									16'd0, 1'b1};
								n = 2'd2;
							end
						end
						best_level_d = is_sink_q ? 8'd0 : rlre_pkg::NONE8;
						best_sink_d  = is_sink_q ? self_id_q : rlre_pkg::NONE8;
					end else begin
						left_d = left_q - 16'd1;
					end
				end
			end
			rlre_pkg::REQ_SETUP: begin
				if (!is_sink_q) begin
					if (!armed_q) begin
						armed_d      = 1'b1;
						left_d       = win_q;
						best_level_d = rlre_pkg::NONE8;
						best_sink_d  = rlre_pkg::NONE8;
					end
					if (bl_eff == rlre_pkg::NONE8 || bl_eff > slev_s1) begin
						best_level_d = slev_s1;
						best_sink_d  = psink_s1;
					end
				end
			end
			rlre_pkg::REQ_DATA: begin
				res[0] = '{rlre_pkg::ACT_DROP, 8'd0, 8'd0, 16'd0, 1'b1};
				n      = 2'd1;
				unique case (dst_s1)
					rlre_pkg::DST_BCAST, rlre_pkg::DST_SELF: begin
						res[0].action = rlre_pkg::ACT_DELIVER;
					end
					rlre_pkg::DST_SINK: begin
						if (lvl_ok) begin
							if (self_id_q == psink_s1) begin
								if (filt_ok) begin
									tbl_upd       = 1'b1;
									res[0].action = rlre_pkg::ACT_DELIVER;
								end
							end else if (psink_s1 == own_sink_q) begin
								res[0] = '{rlre_pkg::ACT_REBCAST, slev_s1, psink_s1,
									pseq_s1, 1'b1};
							end
						end
					end
					rlre_pkg::DST_PARENT: begin
						if (lvl_ok && psink_s1 == own_sink_q && filt_ok) begin
							tbl_upd       = 1'b1;
							res[0].action = rlre_pkg::ACT_DELIVER;
						end
					end
					default: begin
					end
				endcase
			end
			rlre_pkg::REQ_APP: begin
				if (dst_s1 == rlre_pkg::DST_SINK || dst_s1 == rlre_pkg::DST_PARENT) begin
					next_seq_d = next_seq_q + 16'd1;
					if (joined_q) begin
						res[0] = '{rlre_pkg::ACT_SEND, own_level_q, own_sink_q,
							next_seq_q, 1'b1};
						n = 2'd1;
					end else begin
						holding_d = 1'b1;
						res[0] = '{rlre_pkg::ACT_HOLD, own_level_q, own_sink_q,
							next_seq_q, 1'b0};
						res[1] = '{rlre_pkg::ACT_NOT_CONN, own_level_q, own_sink_q,
							16'd0, 1'b1};
						n = 2'd2;
					end
				end else begin
					res[0] = '{rlre_pkg::ACT_SEND, own_level_q, own_sink_q, 16'd0, 1'b1};
					n = 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign wr.en  = fire && tbl_upd;
	assign wr.src = src_s1;
	assign wr.seq = pseq_s1;

	assign clr_start = fire && req_s1 == rlre_pkg::REQ_START;

	assign emit.fire = fire;
	assign emit.n    = n;
	assign emit.res  = res;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1   <= req.req_type;
			dst_s1   <= req.dst_kind;
			src_s1   <= req.src_addr;
			slev_s1  <= req.sender_level;
			psink_s1 <= req.pkt_sink;
			pseq_s1  <= req.pkt_seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			is_sink_q    <= 1'b0;
			self_id_q    <= 8'd0;
			win_q        <= 16'd1000;
			own_level_q  <= rlre_pkg::NONE8;
			own_sink_q   <= rlre_pkg::NONE8;
			best_level_q <= rlre_pkg::NONE8;
			best_sink_q  <= rlre_pkg::NONE8;
			joined_q     <= 1'b0;
			armed_q      <= 1'b0;
			left_q       <= 16'd0;
			next_seq_q   <= 16'd0;
			holding_q    <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					rlre_pkg::CFG_IS_SINK:  is_sink_q <= cfg.data[0];
					rlre_pkg::CFG_SELF_ID:  self_id_q <= cfg.data[7:0];
					rlre_pkg::CFG_WIN_TICK: win_q     <= cfg.data;
					default: begin
					end
				endcase
			end
			if (fire) begin
				own_level_q  <= own_level_d;
				own_sink_q   <= own_sink_d;
				best_level_q <= best_level_d;
				best_sink_q  <= best_sink_d;
				joined_q     <= joined_d;
				armed_q      <= armed_d;
				left_q       <= left_d;
				next_seq_q   <= next_seq_d;
				holding_q    <= holding_d;
			end
		end
	end

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !clearing)
		else $error("event taken while filter is being cleared");

	a_start_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		clr_start |=> clearing && !valid_s1)
		else $error("start did not begin a clearing sweep");

endmodule

// ----- design/rlre_out_buf.sv -----
// result buffer for up to three words per event and the output register
module rlre_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  rlre_pkg::emit_t emit,
	output logic            buf_free,
	rlre_rsp_if.source      rsp
);

	rlre_pkg::result_t res_q [3];
	rlre_pkg::result_t out_q;
	logic [1:0]        cnt_q;
	logic              out_valid_q;
	logic              move;
	logic              load;

	assign move     = cnt_q != 2'd0 && (!out_valid_q || rsp.ready);
	assign buf_free = cnt_q == 2'd0 || (cnt_q == 2'd1 && move);
	assign load     = emit.fire && emit.n != 2'd0;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q[0] <= emit.res[0];
			res_q[1] <= emit.res[1];
			res_q[2] <= emit.res[2];
		end else if (move) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
		if (move) begin
			out_q <= res_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= emit.n;
			end else if (move) begin
				cnt_q <= cnt_q - 2'd1;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.action    = out_q.action;
	assign rsp.level_out = out_q.level;
	assign rsp.sink_out  = out_q.sink;
	assign rsp.seq_out   = out_q.seq;
	assign rsp.last      = out_q.last;

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> buf_free)
		else $error("result buffer overwritten before drained");

	a_word_from_buf: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cnt_q) != 2'd0)
		else $error("output word without a buffered result");

endmodule

// ----- design/ring_level_routing_engine.sv -----
// top level of the ring level routing engine
//
//   channel  dir  handshake        word
//   req      in   valid / ready    one event: type, destination, packet fields
//   rsp      out  valid / ready    one result: action, level, sink, seq, last
//   cfg      in   valid / ready    register write: index, data (always ready)
//
// an event is taken with a filter table read and held in the event stage until
// the result buffer is free; its results reach rsp through that buffer and the
// output register; while rsp is ready, events giving at most one result flow
// at one per cycle and an event with n results holds the buffer until its n
// words are out, one per cycle; after reset and after every start event the
// filter table is swept, one entry a cycle, with req.ready low meanwhile; a
// stalled rsp backs up into the result buffer and then into req.ready
module ring_level_routing_engine #(
	parameter int MAX_NODES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	rlre_req_if.sink    req,
	rlre_rsp_if.source  rsp,
	rlre_cfg_if.sink    cfg
);

	logic                 rd_en;
	logic [7:0]           rd_src;
	rlre_pkg::tbl_wr_t    wr;
	logic                 clr_start;
	rlre_pkg::tbl_entry_t rd_entry;
	logic                 clearing;
	logic                 buf_free;
	rlre_pkg::emit_t      emit;

	rlre_src_table #(
		.MAX_NODES(MAX_NODES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_src   (rd_src),
		.wr       (wr),
		.clr_start(clr_start),
		.rd_entry (rd_entry),
		.clearing (clearing)
	);

	rlre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.rd_en    (rd_en),
		.rd_src   (rd_src),
		.wr       (wr),
		.clr_start(clr_start),
		.rd_entry (rd_entry),
		.clearing (clearing),
		.buf_free (buf_free),
		.emit     (emit)
	);

	rlre_out_buf u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.emit    (emit),
		.buf_free(buf_free),
		.rsp     (rsp)
	);

endmodule
